[sv/assert_macros.svh]
// Assertion macros for the RTL, included by the gaussian pair core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is asserted.
`define BMG_ASSERT(lbl, clk_s, rstn_s, prop, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) else $error(msg);

// Clocked check that also holds during reset.
`define BMG_ASSERT_ALWAYS(lbl, clk_s, prop, msg) \
    lbl: assert property (@(posedge clk_s) prop) else $error(msg);

`endif

[sv/bmg_pkg.sv]
// Types, constants and table-building functions of the Box-Muller gaussian pair core.
`default_nettype none

package bmg_pkg;

    localparam int INDEX_W    = 10;
    localparam int SAMPLE_W   = 32;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;
    localparam int RADIUS_W   = 32;
    localparam int TRIG_W     = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_MEAN     = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VARIANCE = 4'd1;

    localparam logic [31:0] VARIANCE_RESET = 32'd65536;
    localparam logic [31:0] LN2_Q32        = 32'd2977044472;
    localparam logic [31:0] HALF_PI_Q30    = 32'd1686629713;
    localparam logic [31:0] ONE_Q30        = 32'd1073741824;

    typedef struct packed {
        logic neg;
        logic is_sine;
        logic last;
    } op_ctl_t;

    // floor(sqrt(v)), digit by digit
    function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] b;
        v = v_in;
        r = '0;
        b = 64'h4000_0000_0000_0000;
        for (int i = 0; i < 32; i++) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // log2 in Q32 by repeated squaring of a Q31 mantissa
    function automatic logic [63:0] log2_q32(input logic [31:0] m);
        logic [63:0] e;
        logic [63:0] x;
        logic [63:0] frac;
        e = '0;
        frac = '0;
        if (m == '0) begin
            return '0;
        end
        for (int j = 0; j < 31; j++) begin
            if ((m >> (j + 1)) != '0) begin
                e = 64'(j + 1);
            end
        end
        x = 64'(m) << (64'd31 - e);
        for (int i = 0; i < 32; i++) begin
            x = (x * x) >> 31;
            if (x >= 64'h1_0000_0000) begin
                x = x >> 1;
                frac = frac | (64'd1 << (31 - i));
            end
        end
        return (e << 32) | frac;
    endfunction

    // sqrt(-2 ln(k/n)) in Q28
    function automatic logic [RADIUS_W-1:0] radius_q28(input logic [31:0] k,
                                                      input logic [31:0] n);
        logic [63:0] ln_n;
        logic [63:0] lk;
        logic [63:0] d;
        logic [63:0] sv;
        ln_n = log2_q32(n);
        lk = log2_q32(k);
        d = (ln_n > lk) ? ln_n - lk : 64'd0;
        sv = (d >> 32) * 64'(LN2_Q32) * 64'd2
           + (((d & 64'h0000_0000_FFFF_FFFF) * 64'(LN2_Q32)) >> 31);
        return RADIUS_W'(isqrt64(sv << 24));
    endfunction

    // {sin, cos} of a turn fraction, both Q30 signed
    function automatic logic [2*TRIG_W-1:0] sincos_turn(input logic [31:0] t);
        logic [1:0]  q;
        logic [31:0] f;
        logic [31:0] g;
        logic        swap;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] ssum;
        logic [63:0] csum;
        logic [63:0] tmp;
        logic [31:0] cb;
        logic [31:0] sb;
        logic [31:0] c;
        logic [31:0] s;
        q = t[31:30];
        f = {2'b00, t[29:0]};
        swap = f > 32'h2000_0000;
        g = swap ? 32'h4000_0000 - f : f;
        x = (64'(g) * 64'(HALF_PI_Q30)) >> 30;
        x2 = (x * x) >> 30;
        term = x;
        ssum = x;
        term = ((term * x2) >> 30) / 64'd6;
        ssum = ssum - term;
        term = ((term * x2) >> 30) / 64'd20;
        ssum = ssum + term;
        term = ((term * x2) >> 30) / 64'd42;
        ssum = ssum - term;
        term = ((term * x2) >> 30) / 64'd72;
        ssum = ssum + term;
        term = ((term * x2) >> 30) / 64'd110;
        ssum = ssum - term;
        term = 64'(ONE_Q30);
        csum = 64'(ONE_Q30);
        term = ((term * x2) >> 30) / 64'd2;
        csum = csum - term;
        term = ((term * x2) >> 30) / 64'd12;
        csum = csum + term;
        term = ((term * x2) >> 30) / 64'd30;
        csum = csum - term;
        term = ((term * x2) >> 30) / 64'd56;
        csum = csum + term;
        term = ((term * x2) >> 30) / 64'd90;
        csum = csum - term;
        term = ((term * x2) >> 30) / 64'd132;
        csum = csum + term;
        if (swap) begin
            tmp = ssum;
            ssum = csum;
            csum = tmp;
        end
        cb = csum[31:0];
        sb = ssum[31:0];
        case (q)
            2'd0:
            begin
                c = cb;
                s = sb;
            end
            2'd1:
            begin
                c = -sb;
                s = cb;
            end
            2'd2:
            begin
                c = -cb;
                s = -sb;
            end
            default:
            begin
                c = sb;
                s = -cb;
            end
        endcase
        return {s, c};
    endfunction

endpackage

`default_nettype wire

[sv/bmg_if.sv]
// Channel interfaces: uniform pair input, gaussian sample output, register writes.
`default_nettype none

interface bmg_uniform_if;
    logic                         valid;
    logic                         ready;
    logic [bmg_pkg::INDEX_W-1:0]  u1_index;
    logic [bmg_pkg::INDEX_W-1:0]  u2_index;
    logic                         only_first;

    modport source (output valid, output u1_index, output u2_index, output only_first,
                    input ready);
    modport sink (input valid, input u1_index, input u2_index, input only_first,
                  output ready);
endinterface

interface bmg_sample_if;
    logic                         valid;
    logic                         ready;
    logic [bmg_pkg::SAMPLE_W-1:0] sample;
    logic                         is_sine;
    logic                         last;

    modport source (output valid, output sample, output is_sine, output last, input ready);
    modport sink (input valid, input sample, input is_sine, input last, output ready);
endinterface

interface bmg_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [bmg_pkg::CFG_IDX_W-1:0]  index;
    logic [bmg_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[sv/bmg_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module bmg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[sv/box_muller_gaussian_pair_core.sv]
// Box-Muller gaussian pair core: uniform index pairs in, Q16.16 gaussian samples out.
//
// uniform: valid/ready transaction carrying u1_index, u2_index (1..UNIFORM_STEPS) and
//   only_first. A pair with an index of zero or above UNIFORM_STEPS is taken and dropped
//   with no sample; the source redraws.
// gauss: one sample per transaction, cosine sample first (is_sine = 0), then the sine
//   sample unless only_first was set; last marks the final sample of the pair.
// cfg: register writes, index 0 = mean (signed), index 1 = variance (unsigned). A
//   variance write starts a bit-serial square root for the standard deviation; cfg and
//   uniform hold ready low until it completes.
// Order: the lookup stage issues the cosine sample of a pair, then its sine sample, and
//   takes the next pair as the last sample of the current one moves on. It issues one
//   sample a cycle while gauss.ready does not hold the pipeline, into a 4-stage multiply,
//   round and saturate pipeline.
// Reset: mean 0, variance 1.0. The radius and angle tables are then loaded into RAM,
//   one entry per cycle, UNIFORM_STEPS + 1 entries, with uniform.ready low meanwhile.
// Stall: every stage holds while gauss.ready is low; empty stages still fill, so pairs
//   keep being taken until the pipeline is full.
`default_nettype none
`include "assert_macros.svh"

module box_muller_gaussian_pair_core #(
    parameter int UNIFORM_STEPS = 1000,
    parameter int FRAC_BITS     = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    bmg_uniform_if.sink  uniform,
    bmg_sample_if.source gauss,
    bmg_cfg_if.sink      cfg
);

    localparam int AW       = $clog2(UNIFORM_STEPS + 1);
    localparam int SdShift  = 32 - (FRAC_BITS % 2);
    localparam int OutShift = 28 + (FRAC_BITS + SdShift) / 2 - FRAC_BITS;
    localparam int MW       = 64 - OutShift;
    localparam logic [63:0] RoundHalf = 64'd1 << (OutShift - 1);
    localparam logic [31:0] SdReset =
        32'(bmg_pkg::isqrt64(64'(bmg_pkg::VARIANCE_RESET) << SdShift));

    // constant tables, copied into RAM after reset
    logic [bmg_pkg::RADIUS_W-1:0]   rad_rom  [UNIFORM_STEPS + 1];
    logic [2*bmg_pkg::TRIG_W-1:0]   trig_rom [UNIFORM_STEPS + 1];

    for (genvar k = 0; k <= UNIFORM_STEPS; k++)
    begin : g_rom
        localparam logic [31:0] Turn =
            32'(((64'(k) << 32) + 64'(UNIFORM_STEPS / 2)) / UNIFORM_STEPS);
        localparam logic [bmg_pkg::RADIUS_W-1:0] Rad = (k == 0) ? '0 :
            bmg_pkg::radius_q28(32'(k), 32'(UNIFORM_STEPS));
        localparam logic [2*bmg_pkg::TRIG_W-1:0] Trig = (k == 0) ? '0 :
            bmg_pkg::sincos_turn(Turn);
        assign rad_rom[k]  = Rad;
        assign trig_rom[k] = Trig;
    end

    // table load sweep
    logic          fill_active_reg;
    logic [AW-1:0] fill_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_active_reg <= 1'b1;
            fill_cnt_reg    <= '0;
        end
        else if (fill_active_reg)
        begin
            if (fill_cnt_reg == AW'(UNIFORM_STEPS))
            begin
                fill_active_reg <= 1'b0;
            end
            else
            begin
                fill_cnt_reg <= fill_cnt_reg + 1'b1;
            end
        end
    end

    // registers and standard deviation square root
    logic        cfg_acc;
    logic [31:0] mean_reg;
    logic [31:0] sd_reg;
    logic        sq_busy_reg;
    logic [4:0]  sq_cnt_reg;
    logic [63:0] sq_val_reg;
    logic [33:0] sq_rem_reg;
    logic [31:0] sq_root_reg;
    logic [35:0] sq_rem_sh;
    logic [35:0] sq_trial;
    logic        sq_take;
    logic [31:0] sq_root_next;

    assign cfg.ready    = !sq_busy_reg;
    assign cfg_acc      = cfg.valid && cfg.ready;
    assign sq_rem_sh    = {sq_rem_reg, sq_val_reg[63:62]};
    assign sq_trial     = {2'b00, sq_root_reg, 2'b01};
    assign sq_take      = sq_rem_sh >= sq_trial;
    assign sq_root_next = {sq_root_reg[30:0], sq_take};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mean_reg    <= '0;
            sd_reg      <= SdReset;
            sq_busy_reg <= 1'b0;
            sq_cnt_reg  <= '0;
        end
        else
        begin
            if (cfg_acc && cfg.index == bmg_pkg::CFG_MEAN)
            begin
                mean_reg <= cfg.data;
            end
            if (cfg_acc && cfg.index == bmg_pkg::CFG_VARIANCE)
            begin
                sq_busy_reg <= 1'b1;
                sq_cnt_reg  <= 5'd31;
            end
            else if (sq_busy_reg)
            begin
                sq_cnt_reg <= sq_cnt_reg - 5'd1;
                if (sq_cnt_reg == 5'd0)
                begin
                    sq_busy_reg <= 1'b0;
                    sd_reg      <= sq_root_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cfg_acc && cfg.index == bmg_pkg::CFG_VARIANCE)
        begin
            sq_val_reg  <= 64'(cfg.data) << SdShift;
            sq_rem_reg  <= '0;
            sq_root_reg <= '0;
        end
        else if (sq_busy_reg)
        begin
            sq_val_reg  <= {sq_val_reg[61:0], 2'b00};
            sq_rem_reg  <= sq_take ? 34'(sq_rem_sh - sq_trial) : sq_rem_sh[33:0];
            sq_root_reg <= sq_root_next;
        end
    end

    // stage readiness
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic ready2, ready3, ready4, ready5;

    assign ready5 = !v5_reg || gauss.ready;
    assign ready4 = !v4_reg || ready5;
    assign ready3 = !v3_reg || ready4;
    assign ready2 = !v2_reg || ready3;

    // input decode and lookup stage
    logic [16:0] u1_ext;
    logic [16:0] u2_ext;
    logic        reject;
    logic        in_acc;
    logic        rd_en;
    logic        s1_done;
    logic        phase1_reg;
    logic        one1_reg;

    assign u1_ext  = 17'(uniform.u1_index);
    assign u2_ext  = 17'(uniform.u2_index);
    assign reject  = (u1_ext == '0) || (u2_ext == '0) ||
                     (u1_ext > 17'(UNIFORM_STEPS)) || (u2_ext > 17'(UNIFORM_STEPS));
    assign s1_done = v1_reg && ready2 && (phase1_reg || one1_reg);
    assign uniform.ready = !fill_active_reg && !sq_busy_reg && (!v1_reg || s1_done);
    assign in_acc  = uniform.valid && uniform.ready;
    assign rd_en   = in_acc && !reject;

    logic [bmg_pkg::RADIUS_W-1:0] rad_q;
    logic [2*bmg_pkg::TRIG_W-1:0] trig_q;

    bmg_ram #(
        .WIDTH (bmg_pkg::RADIUS_W),
        .DEPTH (UNIFORM_STEPS + 1)
    ) u_rad_ram (
        .clk   (clk),
        .we    (fill_active_reg),
        .waddr (fill_cnt_reg),
        .wdata (rad_rom[fill_cnt_reg]),
        .re    (rd_en),
        .raddr (u1_ext[AW-1:0]),
        .rdata (rad_q)
    );

    bmg_ram #(
        .WIDTH (2 * bmg_pkg::TRIG_W),
        .DEPTH (UNIFORM_STEPS + 1)
    ) u_trig_ram (
        .clk   (clk),
        .we    (fill_active_reg),
        .waddr (fill_cnt_reg),
        .wdata (trig_rom[fill_cnt_reg]),
        .re    (rd_en),
        .raddr (u2_ext[AW-1:0]),
        .rdata (trig_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg     <= 1'b0;
            phase1_reg <= 1'b0;
            one1_reg   <= 1'b0;
        end
        else if (in_acc)
        begin
            v1_reg     <= !reject;
            phase1_reg <= 1'b0;
            one1_reg   <= uniform.only_first;
        end
        else if (s1_done)
        begin
            v1_reg <= 1'b0;
        end
        else if (v1_reg && ready2)
        begin
            phase1_reg <= 1'b1;
        end
    end

    // stage 2: radius times |trig|
    logic [bmg_pkg::TRIG_W-1:0] trig_sel;
    logic [31:0]                trig_mag;
    logic [63:0]                prod1;
    bmg_pkg::op_ctl_t           ctl1;
    bmg_pkg::op_ctl_t           ctl2_reg, ctl3_reg, ctl4_reg, ctl5_reg;
    logic [31:0]                rt2_reg;

    assign trig_sel = phase1_reg ? trig_q[2*bmg_pkg::TRIG_W-1:bmg_pkg::TRIG_W]
                                 : trig_q[bmg_pkg::TRIG_W-1:0];
    assign trig_mag = trig_sel[bmg_pkg::TRIG_W-1] ? 32'(~trig_sel + 1'b1) : 32'(trig_sel);
    assign prod1    = 64'(rad_q) * 64'(trig_mag);
    assign ctl1.neg     = trig_sel[bmg_pkg::TRIG_W-1];
    assign ctl1.is_sine = phase1_reg;
    assign ctl1.last    = phase1_reg || one1_reg;

    // stage 3: times standard deviation; stage 4: round, shift, sign
    logic [63:0]          p3_reg;
    logic [63:0]          rsum;
    logic [MW-1:0]        mag4;
    logic signed [MW:0]   sm_next;
    logic signed [MW:0]   sm4_reg;

    assign rsum    = p3_reg + RoundHalf;
    assign mag4    = rsum[63 -: MW];
    assign sm_next = ctl3_reg.neg ? -$signed({1'b0, mag4}) : $signed({1'b0, mag4});

    // stage 5: add mean, saturate
    logic [33:0]                  total;
    logic [bmg_pkg::SAMPLE_W-1:0] sample_next;
    logic [bmg_pkg::SAMPLE_W-1:0] sample5_reg;

    assign total = {{(33 - MW){sm4_reg[MW]}}, sm4_reg} + {{2{mean_reg[31]}}, mean_reg};

    always_comb
    begin
        if (!total[33] && (total[32] || total[31]))
        begin
            sample_next = 32'h7FFF_FFFF;
        end
        else if (total[33] && !(total[32] && total[31]))
        begin
            sample_next = 32'h8000_0000;
        end
        else
        begin
            sample_next = total[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (ready2)
            begin
                v2_reg <= v1_reg;
            end
            if (ready3)
            begin
                v3_reg <= v2_reg;
            end
            if (ready4)
            begin
                v4_reg <= v3_reg;
            end
            if (ready5)
            begin
                v5_reg <= v4_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready2)
        begin
            rt2_reg  <= prod1[61:30];
            ctl2_reg <= ctl1;
        end
        if (ready3)
        begin
            p3_reg   <= 64'(rt2_reg) * 64'(sd_reg);
            ctl3_reg <= ctl2_reg;
        end
        if (ready4)
        begin
            sm4_reg  <= sm_next;
            ctl4_reg <= ctl3_reg;
        end
        if (ready5)
        begin
            sample5_reg <= sample_next;
            ctl5_reg    <= ctl4_reg;
        end
    end

    assign gauss.valid   = v5_reg;
    assign gauss.sample  = sample5_reg;
    assign gauss.is_sine = ctl5_reg.is_sine;
    assign gauss.last    = ctl5_reg.last;

    `BMG_ASSERT(a_second_needs_pair, clk, rst_n, v1_reg && phase1_reg |-> !one1_reg, "sine phase on a single-sample transaction")
    `BMG_ASSERT(a_sine_is_last, clk, rst_n, v5_reg && ctl5_reg.is_sine |-> ctl5_reg.last, "sine sample not marked last")
    `BMG_ASSERT(a_fill_empty, clk, rst_n, fill_active_reg |-> !v1_reg && !v5_reg, "pipeline active during table load")
    `BMG_ASSERT(a_var_starts_sqrt, clk, rst_n, cfg_acc && cfg.index == bmg_pkg::CFG_VARIANCE |=> sq_busy_reg, "variance write did not start square root")

endmodule

`default_nettype wire

[bench/tb_top.sv]
// Testbench for box_muller_gaussian_pair_core: directed and random uniform pairs, samples checked in order.
`timescale 1ns / 100ps

module tb_top;

    localparam int          STEPS       = 1000;
    localparam int          HOLD_CYCLES = 300;
    localparam int          OUT_SHIFT   = 36;
    localparam logic [63:0] K_LN2       = 64'd2977044472;
    localparam logic [63:0] K_HALF_PI   = 64'd1686629713;
    localparam logic [63:0] K_ONE       = 64'd1073741824;

    typedef struct {
        logic [31:0] sample;
        logic        is_sine;
        logic        last;
    } gauss_word_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic steady = 1'b0;
    logic stall_out = 1'b0;
    int   errors = 0;
    event hold_kick;

    logic [31:0]        radius_lut [0:STEPS];
    logic signed [31:0] cos_lut [0:STEPS];
    logic signed [31:0] sin_lut [0:STEPS];
    logic signed [31:0] mean_q;
    logic [63:0]        sd_q;
    gauss_word_t        pending_samples [$];
    gauss_word_t        want;

    bmg_uniform_if uniform_ch ();
    bmg_sample_if  gauss_ch ();
    bmg_cfg_if     cfg_ch ();

    box_muller_gaussian_pair_core #(
        .UNIFORM_STEPS (STEPS),
        .FRAC_BITS     (16)
    ) u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .uniform (uniform_ch),
        .gauss   (gauss_ch),
        .cfg     (cfg_ch)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic logic [63:0] sqrt_floor64(input logic [63:0] v_in);
        logic [63:0] rem;
        logic [63:0] root;
        logic [63:0] place;
        rem = v_in;
        root = '0;
        place = 64'h4000_0000_0000_0000;
        while (place > rem)
        begin
            place = place >> 2;
        end
        while (place != 0)
        begin
            if (rem >= root + place)
            begin
                rem = rem - (root + place);
                root = (root >> 1) + place;
            end
            else
            begin
                root = root >> 1;
            end
            place = place >> 2;
        end
        return root;
    endfunction

    // Q32 log2: integer part from the top set bit, fraction by squaring the Q31 mantissa
    function automatic logic [63:0] log2_fixed32(input logic [31:0] m);
        int unsigned ex;
        logic [63:0] x;
        logic [63:0] fr;
        ex = 0;
        fr = '0;
        if (m == 0)
        begin
            return '0;
        end
        while (ex < 31 && (m >> (ex + 1)) != 0)
        begin
            ex++;
        end
        x = 64'(m) << (31 - ex);
        for (int i = 0; i < 32; i++)
        begin
            x = (x * x) >> 31;
            if (x >= 64'h1_0000_0000)
            begin
                x = x >> 1;
                fr = fr | (64'd1 << (31 - i));
            end
        end
        return (64'(ex) << 32) | fr;
    endfunction

    // octant fold, Taylor series in Q30, then quadrant unfold
    function automatic void turn_to_cos_sin(input logic [31:0] t,
                                            output logic signed [31:0] c,
                                            output logic signed [31:0] s);
        logic [31:0]        f;
        logic [31:0]        g;
        logic               swap;
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic [63:0]        ssum;
        logic [63:0]        csum;
        logic [63:0]        tmp;
        logic signed [31:0] cb;
        logic signed [31:0] sb;
        f = {2'b00, t[29:0]};
        swap = f > 32'h2000_0000;
        g = swap ? 32'h4000_0000 - f : f;
        x = (64'(g) * K_HALF_PI) >> 30;
        x2 = (x * x) >> 30;
        term = x;
        ssum = x;
        for (int n = 1; n <= 5; n++)
        begin
            term = ((term * x2) >> 30) / (64'(2 * n) * 64'(2 * n + 1));
            ssum = (n % 2 == 1) ? ssum - term : ssum + term;
        end
        term = K_ONE;
        csum = K_ONE;
        for (int n = 1; n <= 6; n++)
        begin
            term = ((term * x2) >> 30) / (64'(2 * n - 1) * 64'(2 * n));
            csum = (n % 2 == 1) ? csum - term : csum + term;
        end
        if (swap)
        begin
            tmp = ssum;
            ssum = csum;
            csum = tmp;
        end
        cb = csum[31:0];
        sb = ssum[31:0];
        case (t[31:30])
            2'd0:
            begin
                c = cb;
                s = sb;
            end
            2'd1:
            begin
                c = -sb;
                s = cb;
            end
            2'd2:
            begin
                c = -cb;
                s = -sb;
            end
            default:
            begin
                c = sb;
                s = -cb;
            end
        endcase
    endfunction

    function automatic void build_lookup();
        logic [63:0] ln_n;
        logic [63:0] lk;
        logic [63:0] d;
        logic [63:0] sv;
        logic [63:0] t;
        ln_n = log2_fixed32(STEPS);
        radius_lut[0] = '0;
        cos_lut[0] = '0;
        sin_lut[0] = '0;
        for (int k = 1; k <= STEPS; k++)
        begin
            lk = log2_fixed32(32'(k));
            d = (ln_n > lk) ? ln_n - lk : 64'd0;
            sv = (d >> 32) * K_LN2 * 64'd2 + (((d & 64'hFFFF_FFFF) * K_LN2) >> 31);
            radius_lut[k] = 32'(sqrt_floor64(sv << 24));
            t = ((64'(k) << 32) + 64'(STEPS / 2)) / 64'(STEPS);
            turn_to_cos_sin(t[31:0], cos_lut[k], sin_lut[k]);
        end
    endfunction

    function automatic logic [31:0] gaussian_value(input logic [31:0] r,
                                                   input logic signed [31:0] trig);
        logic        neg;
        logic [63:0] mag;
        logic [63:0] rt;
        logic [63:0] m;
        longint      v;
        neg = trig < 0;
        mag = 64'(neg ? -longint'(trig) : longint'(trig));
        rt = (64'(r) * mag) >> 30;
        m = (rt * sd_q + (64'd1 << (OUT_SHIFT - 1))) >> OUT_SHIFT;
        v = neg ? -longint'(m) : longint'(m);
        v = v + longint'(mean_q);
        if (v > 64'sd2147483647)
        begin
            v = 64'sd2147483647;
        end
        if (v < -64'sd2147483648)
        begin
            v = -64'sd2147483648;
        end
        return v[31:0];
    endfunction

    function automatic void predict_pair(input logic [9:0] u1, input logic [9:0] u2,
                                         input logic single);
        gauss_word_t w;
        if (u1 == 0 || u2 == 0 || u1 > STEPS || u2 > STEPS)
        begin
            return;
        end
        w.sample = gaussian_value(radius_lut[u1], cos_lut[u2]);
        w.is_sine = 1'b0;
        w.last = single;
        pending_samples.push_back(w);
        if (!single)
        begin
            w.sample = gaussian_value(radius_lut[u1], sin_lut[u2]);
            w.is_sine = 1'b1;
            w.last = 1'b1;
            pending_samples.push_back(w);
        end
    endfunction

    task automatic send_pair(input logic [9:0] u1, input logic [9:0] u2, input logic single);
        if (!steady && $urandom_range(99) < 8)
        begin
            uniform_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        uniform_ch.valid <= 1'b1;
        uniform_ch.u1_index <= u1;
        uniform_ch.u2_index <= u2;
        uniform_ch.only_first <= single;
        do @(posedge clk); while (!uniform_ch.ready);
        predict_pair(u1, u2, single);
    endtask

    // mostly well-formed pairs; the rest carry a zero or out-of-range index
    task automatic send_random_pair(output bit counted);
        logic [9:0]  a;
        logic [9:0]  b;
        int unsigned pick;
        a = 10'($urandom_range(1, STEPS));
        b = 10'($urandom_range(1, STEPS));
        counted = 1'b1;
        if ($urandom_range(99) < 8)
        begin
            counted = 1'b0;
            pick = $urandom_range(2);
            if (pick != 1)
            begin
                a = $urandom_range(1) ? 10'd0 : 10'($urandom_range(STEPS + 1, 1023));
            end
            if (pick != 0)
            begin
                b = $urandom_range(1) ? 10'd0 : 10'($urandom_range(STEPS + 1, 1023));
            end
        end
        send_pair(a, b, 1'($urandom_range(1)));
    endtask

    task automatic wait_drained();
        uniform_ch.valid <= 1'b0;
        while (pending_samples.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (12) @(posedge clk);
    endtask

    task automatic set_config(input logic [31:0] mean_val, input logic [31:0] var_val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= bmg_pkg::CFG_MEAN;
        cfg_ch.data <= mean_val;
        do @(posedge clk); while (!cfg_ch.ready);
        mean_q = mean_val;
        cfg_ch.index <= bmg_pkg::CFG_VARIANCE;
        cfg_ch.data <= var_val;
        do @(posedge clk); while (!cfg_ch.ready);
        sd_q = sqrt_floor64(64'(var_val) << 32);
        cfg_ch.valid <= 1'b0;
    endtask

    // runs on reset values of mean and variance
    task automatic test_directed();
        send_pair(10'd1000, 10'd1000, 1'b0);
        send_pair(10'd1, 10'd1, 1'b0);
        send_pair(10'd1, 10'd250, 1'b0);
        send_pair(10'd1, 10'd500, 1'b0);
        send_pair(10'd1, 10'd750, 1'b0);
        send_pair(10'd1, 10'd1000, 1'b1);
        send_pair(10'd500, 10'd125, 1'b0);
        send_pair(10'd999, 10'd1, 1'b0);
        send_pair(10'd2, 10'd999, 1'b1);
        send_pair(10'd511, 10'd512, 1'b0);
        send_pair(10'd0, 10'd5, 1'b0);
        send_pair(10'd5, 10'd0, 1'b0);
        send_pair(10'd0, 10'd0, 1'b1);
        send_pair(10'd1001, 10'd3, 1'b0);
        send_pair(10'd3, 10'd1001, 1'b0);
        send_pair(10'd1023, 10'd1023, 1'b1);
        send_pair(10'd1000, 10'd250, 1'b1);
        wait_drained();
    endtask

    task automatic test_extremes();
        logic [31:0] m;
        logic [31:0] v;
        bit          counted;
        for (int s = 0; s < 5; s++)
        begin
            case (s)
                0:
                begin
                    m = 32'h7FFF_FFFF;
                    v = 32'hFFFF_FFFF;
                end
                1:
                begin
                    m = 32'h8000_0000;
                    v = 32'hFFFF_FFFF;
                end
                2:
                begin
                    m = 32'h0000_0000;
                    v = 32'h0000_0000;
                end
                3:
                begin
                    m = 32'h7FFF_0000;
                    v = 32'h0001_0000;
                end
                default:
                begin
                    m = 32'hFFFF_8000;
                    v = 32'h0004_0000;
                end
            endcase
            set_config(m, v);
            send_pair(10'd1, 10'd1, 1'b0);
            send_pair(10'd1, 10'd500, 1'b0);
            send_pair(10'd1000, 10'd1000, 1'b0);
            repeat (5) send_random_pair(counted);
            wait_drained();
        end
    endtask

    task automatic test_back_to_back();
        bit counted;
        set_config(32'h0001_8000, 32'h0002_0000);
        steady <= 1'b1;
        repeat (200) send_random_pair(counted);
        wait_drained();
        steady <= 1'b0;
    endtask

    // output held off while pairs keep coming, so the pipeline fills and stalls input
    task automatic test_backpressure();
        bit counted;
        -> hold_kick;
        repeat (40) send_random_pair(counted);
        wait_drained();
    endtask

    task automatic test_random();
        logic [31:0] m;
        logic [31:0] v;
        int          good;
        bit          counted;
        for (int phase = 0; phase < 7; phase++)
        begin
            m = $urandom;
            if ($urandom_range(1))
            begin
                m = {{12{m[31]}}, m[19:0]};
            end
            v = $urandom >> $urandom_range(0, 31);
            set_config(m, v);
            good = 0;
            while (good < 100)
            begin
                send_random_pair(counted);
                if (counted)
                begin
                    good++;
                end
            end
            wait_drained();
        end
    endtask

    always @(posedge clk)
    begin
        gauss_ch.ready <= !stall_out && (steady || $urandom_range(99) >= 8);
    end

    always
    begin
        @(hold_kick);
        stall_out <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        stall_out <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && gauss_ch.valid && gauss_ch.ready)
        begin
            if (pending_samples.size() == 0)
            begin
                $display("%0t: expected no transaction, actual sample %h is_sine %b last %b",
                         $time, gauss_ch.sample, gauss_ch.is_sine, gauss_ch.last);
                errors++;
            end
            else
            begin
                want = pending_samples.pop_front();
                if (gauss_ch.sample !== want.sample)
                begin
                    $display("%0t: sample expected %h actual %h",
                             $time, want.sample, gauss_ch.sample);
                    errors++;
                end
                if (gauss_ch.is_sine !== want.is_sine)
                begin
                    $display("%0t: is_sine expected %b actual %b",
                             $time, want.is_sine, gauss_ch.is_sine);
                    errors++;
                end
                if (gauss_ch.last !== want.last)
                begin
                    $display("%0t: last expected %b actual %b",
                             $time, want.last, gauss_ch.last);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        #1_600_000;
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        uniform_ch.valid <= 1'b0;
        uniform_ch.u1_index <= '0;
        uniform_ch.u2_index <= '0;
        uniform_ch.only_first <= 1'b0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= bmg_pkg::CFG_MEAN;
        cfg_ch.data <= '0;
        build_lookup();
        mean_q = '0;
        sd_q = sqrt_floor64(64'(bmg_pkg::VARIANCE_RESET) << 32);
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_extremes();
        test_back_to_back();
        test_backpressure();
        test_random();
        if (errors == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+sv
sv/bmg_pkg.sv
sv/bmg_if.sv
sv/bmg_ram.sv
sv/box_muller_gaussian_pair_core.sv
bench/tb_top.sv
